FILE: rtl/json_string_escape_emitter_macros.svh
// Assertion macros for the JSON string escape emitter.
// Included by the top level; depends on nothing else.
`ifndef JSON_STRING_ESCAPE_EMITTER_MACROS_SVH
`define JSON_STRING_ESCAPE_EMITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define JSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/jse_pkg.sv
// Shared types, constants and the escape encoder for the JSON string escape emitter.
// Depends on nothing; the interfaces, sequencer, emitter and top level use it.
package jse_pkg;

   localparam int CAP_BITS           = 16;
   localparam int POS_BITS           = 16;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int SEQ_DEPTH          = 6;
   localparam int SEQ_IDX_BITS       = $clog2(SEQ_DEPTH);

   typedef enum logic [1:0] {
      FUNC_OPEN   = 2'd0,
      FUNC_BYTE   = 2'd1,
      FUNC_CLOSE  = 2'd2,
      FUNC_REPORT = 2'd3
   } jse_func_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NONE   = 8'h00;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   // One decoded input item: the bytes to emit, index of the final one, report flag.
   typedef struct packed {
      logic [SEQ_DEPTH-1:0][7:0] bytes;
      logic [SEQ_IDX_BITS-1:0]   last_idx;
      logic                      report;
   } jse_seq_type;

   // One output byte handed from the sequencer to the emitter.
   typedef struct packed {
      logic [7:0] ch;
      logic       report;
      logic       last;
   } jse_beat_type;

   // Lowercase hex digit for a nibble.
   function automatic logic [7:0] hex_digit(logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + {4'd0, nib};
      end else begin
         ch = 8'h57 + {4'd0, nib};
      end
      return ch;
   endfunction

   // Expand one command into its output byte sequence.
   function automatic jse_seq_type encode_item(logic [1:0] func, logic [7:0] b);
      jse_seq_type s;
      logic [7:0]  esc;
      s = '0;
      esc = CH_NONE;
      case (jse_func_type'(func))
         FUNC_REPORT: begin
            s.report = 1'b1;
         end
         FUNC_OPEN, FUNC_CLOSE: begin
            s.bytes[0] = CH_QUOTE;
         end
         FUNC_BYTE: begin
            case (b)
               CH_QUOTE:  esc = CH_QUOTE;
               CH_BSLASH: esc = CH_BSLASH;
               CH_BS:     esc = CH_LOW_B;
               CH_FF:     esc = CH_LOW_F;
               CH_LF:     esc = CH_LOW_N;
               CH_CR:     esc = CH_LOW_R;
               CH_TAB:    esc = CH_LOW_T;
               default:   esc = CH_NONE;
            endcase
            if (esc != CH_NONE) begin
               s.bytes[0] = CH_BSLASH;
               s.bytes[1] = esc;
               s.last_idx = SEQ_IDX_BITS'(1);
            end else if (b inside {[8'h00:8'h1F]}) begin
               s.bytes[0] = CH_BSLASH;
               s.bytes[1] = CH_LOW_U;
               s.bytes[2] = CH_ZERO;
               s.bytes[3] = CH_ZERO;
               s.bytes[4] = hex_digit(b[7:4]);
               s.bytes[5] = hex_digit(b[3:0] & NIBBLE_MASK);
               s.last_idx = SEQ_IDX_BITS'(SEQ_DEPTH - 1);
            end else begin
               s.bytes[0] = b;
            end
         end
         default: begin
            s.report = 1'b1;
         end
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/jse_if.sv
// Handshake channel interfaces for the JSON string escape emitter.
// Depends on jse_pkg for field widths.
interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] text_byte;
   modport source (output valid, func, text_byte, input ready);
   modport sink   (input valid, func, text_byte, output ready);
endinterface

interface jse_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [7:0]                   out_byte;
   logic [jse_pkg::POS_BITS-1:0] position;
   logic                         stored;
   logic                         still_valid;
   logic                         last_of_run;
   modport source (output valid, out_byte, position, stored, still_valid, last_of_run,
                   input ready);
   modport sink   (input valid, out_byte, position, stored, still_valid, last_of_run,
                   output ready);
endinterface

interface jse_csr_if;
   logic                         valid;
   logic                         ready;
   logic [jse_pkg::CAP_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/jse_seq.sv
// Input register and byte sequencer: holds one decoded item and steps through its bytes.
// Depends on jse_pkg and the request interface.
module jse_seq (
   input  logic                  clock,
   input  logic                  reset,
   jse_req_if.sink               req,
   input  logic                  beat_take,
   output logic                  beat_valid,
   output jse_pkg::jse_beat_type beat
);
   import jse_pkg::*;

   logic                    hold_valid_ff, hold_valid_in;
   jse_seq_type             seq_ff, seq_in;
   logic [SEQ_IDX_BITS-1:0] idx_ff, idx_in;
   logic                    is_last;
   logic                    accept;

   assign is_last     = (idx_ff == seq_ff.last_idx);
   assign req.ready   = !hold_valid_ff || (beat_take && is_last);
   assign accept      = req.valid && req.ready;
   assign beat_valid  = hold_valid_ff;
   assign beat.ch     = seq_ff.bytes[idx_ff];
   assign beat.report = seq_ff.report;
   assign beat.last   = is_last;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      seq_in        = seq_ff;
      idx_in        = idx_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         seq_in        = encode_item(req.func, req.text_byte);
         idx_in        = '0;
      end else if (beat_take && is_last) begin
         hold_valid_in = 1'b0;
      end else if (beat_take) begin
         idx_in = idx_ff + SEQ_IDX_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         idx_ff        <= idx_in;
      end
      seq_ff <= seq_in;
   end

endmodule

FILE: rtl/jse_emit.sv
// Writer state (count and valid flag) and the result register.
// Depends on jse_pkg and the response interface.
module jse_emit #(
   parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [jse_pkg::CAP_BITS-1:0] capacity,
   input  logic                    beat_valid,
   input  jse_pkg::jse_beat_type   beat,
   output logic                    beat_take,
   jse_rsp_if.source               rsp
);
   import jse_pkg::*;

   localparam int WIDE_BITS = (COUNT_BITS > CAP_BITS ? COUNT_BITS : CAP_BITS) + 1;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  flag_ff, flag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  stored_ff, stored_in;
   logic                  still_ff, still_in;
   logic                  last_ff, last_in;

   logic [WIDE_BITS-1:0]  cap_wide, lim_wide, cap_lim, next_wide;
   logic                  fits;

   assign beat_take = beat_valid && (!rsp_valid_ff || rsp.ready);

   // The counter bounds the usable room as well as the configured capacity.
   assign cap_wide  = WIDE_BITS'(capacity);
   assign lim_wide  = WIDE_BITS'(1) << COUNT_BITS;
   assign cap_lim   = (cap_wide > lim_wide) ? lim_wide : cap_wide;
   assign next_wide = WIDE_BITS'(count_ff) + WIDE_BITS'(1);
   assign fits      = next_wide < cap_lim;

   always_comb begin
      count_in     = count_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      byte_in      = byte_ff;
      pos_in       = pos_ff;
      stored_in    = stored_ff;
      still_in     = still_ff;
      last_in      = last_ff;
      if (beat_take) begin
         rsp_valid_in = 1'b1;
         pos_in       = POS_BITS'(count_ff);
         last_in      = beat.last;
         if (beat.report) begin
            byte_in   = CH_NONE;
            stored_in = 1'b0;
            still_in  = flag_ff;
         end else begin
            byte_in   = beat.ch;
            stored_in = flag_ff && fits;
            flag_in   = flag_ff && fits;
            still_in  = flag_ff && fits;
            if (flag_ff && fits) begin
               count_in = COUNT_BITS'(next_wide);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         flag_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff   <= byte_in;
      pos_ff    <= pos_in;
      stored_ff <= stored_in;
      still_ff  <= still_in;
      last_ff   <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.position    = pos_ff;
   assign rsp.stored      = stored_ff;
   assign rsp.still_valid = still_ff;
   assign rsp.last_of_run = last_ff;

endmodule

FILE: rtl/json_string_escape_emitter.sv
// Top level of the JSON string escape emitter: capacity register, sequencer and emitter.
// Depends on jse_pkg, the channel interfaces, jse_seq, jse_emit and the macro header.
//
//   channel   dir  beat carries
//   --------  ---  -----------------------------------------------------------
//   req_bus   in   func, text_byte
//   rsp_bus   out  out_byte, position, stored, still_valid, last_of_run
//   csr_bus   in   data (buffer capacity in bytes)
//
// A command that yields one output byte (quote, plain byte, report) is a single beat,
// and such commands stream back to back. An escape gives two beats and a \u00XX escape
// six, one beat per cycle unless rsp_bus stalls; the single item register sets this.
// A first result beat passes the item register, then the emitter's result register.
// Reset is synchronous: count clears, the valid flag sets, capacity clears to zero.
// A stalled rsp_bus holds its beat; one more command is taken, then req_bus.ready drops.
`include "json_string_escape_emitter_macros.svh"

module json_string_escape_emitter #(
   parameter int COUNT_BITS = jse_pkg::COUNT_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   jse_req_if.sink   req_bus,
   jse_rsp_if.source rsp_bus,
   jse_csr_if.sink   csr_bus
);
   import jse_pkg::*;

   // Capacity register. Writes must arrive only while the block is idle; the block
   // does not enforce this. The port is always ready.
   logic [CAP_BITS-1:0] capacity_ff, capacity_in;

   // The sequencer hands one output byte per cycle to the emitter while the emitter takes it.
   logic         beat_valid;
   logic         beat_take;
   jse_beat_type beat;

   assign csr_bus.ready = 1'b1;
   assign capacity_in   = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // The sequencer registers each accepted command already expanded into
   // its escape sequence, then walks it one byte per cycle unless stalled.
   jse_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .beat_take  (beat_take),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   // The emitter applies the capacity check, updates the count and valid flag,
   // and registers the result beat.
   jse_emit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_take  (beat_take),
      .rsp        (rsp_bus)
   );

   // A byte can only be stored while the writer remains valid.
   `JSE_ASSERT_NOW(a_stored_valid, clock, reset, rsp_bus.valid && rsp_bus.stored, rsp_bus.still_valid, "stored byte with writer invalid")

   // Only a report carries a zero byte, and it ends its run without storing.
   `JSE_ASSERT_NOW(a_report_shape, clock, reset, rsp_bus.valid && (rsp_bus.out_byte == CH_NONE), rsp_bus.last_of_run && !rsp_bus.stored, "malformed report beat")

   // Once the writer goes invalid it never recovers.
   `JSE_ASSERT_NEXT(a_invalid_sticky, clock, reset, rsp_bus.valid && rsp_bus.ready && !rsp_bus.still_valid, !rsp_bus.valid || !rsp_bus.still_valid, "valid flag recovered")

   // After a stored byte the next beat sits one position further on.
   `JSE_ASSERT_NEXT(a_position_step, clock, reset, rsp_bus.valid && rsp_bus.ready && rsp_bus.stored, !rsp_bus.valid || (rsp_bus.position == POS_BITS'($past(rsp_bus.position) + POS_BITS'(1))), "position did not advance")

endmodule
